// ===== hw/rtl/tlca_pkg.sv =====
`default_nettype none

package tlca_pkg;

  localparam int NODES     = 65536;
  localparam int LEVELS    = 17;
  localparam int WORD_W    = 16;
  localparam int LEN_W     = 17;
  localparam int NODE_W    = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LVL_W     = $clog2(LEVELS);
  localparam int ANC_AW    = LVL_W + NODE_W;
  localparam int ANC_WORDS = LEVELS << NODE_W;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [NODE_W-1:0] node_t;
  typedef logic [LVL_W-1:0]  lvl_t;
  typedef logic [ANC_AW-1:0] anc_addr_t;
  typedef logic [LEN_W-1:0]  len_t;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_BUILD = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam word_t ROOT_RESET = word_t'(1);

  typedef struct packed {
    anc_addr_t anc_raddr;
    logic      anc_we;
    anc_addr_t anc_waddr;
    word_t     anc_wdata;
    node_t     dep_raddr;
    logic      dep_we;
    node_t     dep_waddr;
    word_t     dep_wdata;
  } mem_req_t;

  typedef struct packed {
    word_t anc_rdata;
    word_t dep_rdata;
  } mem_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tlca_store.sv =====
`default_nettype none

module tlca_store import tlca_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output mem_rsp_t rsp
);

  word_t anc_mem [ANC_WORDS];
  word_t dep_mem [NODES];
  word_t anc_q;
  word_t dep_q;

  always_ff @(posedge clk) begin
    if (req.anc_we) begin
      anc_mem[req.anc_waddr] <= req.anc_wdata;
    end
    anc_q <= anc_mem[req.anc_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.dep_we) begin
      dep_mem[req.dep_waddr] <= req.dep_wdata;
    end
    dep_q <= dep_mem[req.dep_raddr];
  end

  assign rsp = '{anc_rdata: anc_q, dep_rdata: dep_q};

endmodule

`default_nettype wire

// ===== hw/rtl/tree_lca_distance_binary_lifting.sv =====
`default_nettype none
// Binary-lifting ancestor engine for a rooted tree.
// Command word: mode, node_a, node_b; taken at a clock edge with start high
// and busy low. busy stays high until the command's work is finished.
// Result word: kind, ancestor, path_length, shown for one cycle with
// result_valid high. The receiver cannot stall; it must take every word.
// Load (mode 0): no result. Parent must be loaded first.
// Build (mode 1): ends with a done word (kind 0).
//   Each table entry costs two reads of the single table read port.
// Query (mode 2): ends with the answer word (kind 1). Up to two lifting
//   passes over LEVELS levels, two memory reads per level; the second pass
//   is skipped when the first already reaches the common ancestor.
// Mode 3 is dropped without a result.
// cfg_write/cfg_data set root_node; the root is pinned as its own parent at
// depth 0 in the same cycle. Write it only while busy is low.
// Reset (rst, synchronous): root_node returns to 1 and busy stays high
// while the root entry is pinned. Table contents are not cleared.
// One command at a time; the next is taken in the cycle after busy falls.

module tree_lca_distance_binary_lifting import tlca_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        mode,
  input  logic [WORD_W-1:0] node_a,
  input  logic [WORD_W-1:0] node_b,
  input  logic              cfg_write,
  input  logic [WORD_W-1:0] cfg_data,
  output logic              result_valid,
  output logic              kind,
  output logic [WORD_W-1:0] ancestor,
  output logic [LEN_W-1:0]  path_length
);

  typedef enum logic [4:0] {
    S_PIN, S_IDLE, S_LD_RD, S_LD_WR,
    S_B_PIN, S_B_RD1, S_B_RD2, S_B_WR,
    S_Q_DU, S_Q_DV, S_Q_SW,
    S_L1_A, S_L1_B, S_L1_C, S_CHK,
    S_L2_A, S_L2_B, S_L2_C,
    S_FIN_A, S_FIN_B, S_FIN_C
  } state_t;

  state_t   state;
  word_t    root_node;
  node_t    u;
  node_t    v;
  node_t    w;
  node_t    i;
  lvl_t     j;
  word_t    du0;
  word_t    dv0;
  word_t    dcur;
  word_t    dvt;
  mem_req_t req;
  mem_rsp_t rsp;

  function automatic logic in_range(word_t x);
    return ({1'b0, x} < (WORD_W+1)'(NODES));
  endfunction

  function automatic node_t acting(word_t r);
    return in_range(r) ? r[NODE_W-1:0] : '0;
  endfunction

  function automatic node_t fix_node(word_t x, node_t r);
    return in_range(x) ? x[NODE_W-1:0] : r;
  endfunction

  function automatic len_t path_len(word_t a, word_t b, word_t d);
    len_t sum;
    len_t twice;
    sum   = LEN_W'(a) + LEN_W'(b);
    twice = {d, 1'b0};
    return (sum >= twice) ? len_t'(sum - twice) : '0;
  endfunction

  node_t aroot;
  node_t fix_rd;
  logic  take1;
  node_t u1_next;
  node_t u2_next;
  node_t i_next;
  lvl_t  j_next;
  logic  b_last;
  word_t dep_inc;

  assign aroot   = acting(root_node);
  assign fix_rd  = fix_node(rsp.anc_rdata, aroot);
  assign take1   = (rsp.dep_rdata >= dvt);
  assign u1_next = take1 ? w : u;
  assign u2_next = (w != fix_rd) ? w : u;
  assign b_last  = (j == lvl_t'(LEVELS - 1)) && (i == node_t'(NODES - 1));
  assign i_next  = (i == node_t'(NODES - 1)) ? '0 : node_t'(i + 1'b1);
  assign j_next  = (i == node_t'(NODES - 1)) ? lvl_t'(j + 1'b1) : j;
  assign dep_inc = (rsp.dep_rdata == '1) ? rsp.dep_rdata : word_t'(rsp.dep_rdata + 1'b1);
  assign busy    = (state != S_IDLE);

  always_comb begin
    req           = '0;
    req.anc_raddr = {j, u};
    req.dep_raddr = u;
    unique case (state)
      S_PIN, S_B_PIN: begin
        req.anc_we    = 1'b1;
        req.anc_waddr = {lvl_t'(0), aroot};
        req.anc_wdata = WORD_W'(aroot);
        req.dep_we    = 1'b1;
        req.dep_waddr = aroot;
        req.dep_wdata = '0;
      end
      S_LD_RD: req.dep_raddr = v;
      S_LD_WR: begin
        req.anc_we    = 1'b1;
        req.anc_waddr = {lvl_t'(0), u};
        req.anc_wdata = WORD_W'(v);
        req.dep_we    = 1'b1;
        req.dep_waddr = u;
        req.dep_wdata = dep_inc;
      end
      S_B_RD1: req.anc_raddr = {lvl_t'(j - 1'b1), i};
      S_B_RD2: req.anc_raddr = {lvl_t'(j - 1'b1), fix_rd};
      S_B_WR: begin
        req.anc_we    = 1'b1;
        req.anc_waddr = {j, i};
        req.anc_wdata = rsp.anc_rdata;
        if (!b_last) begin
          req.anc_raddr = {lvl_t'(j_next - 1'b1), i_next};
        end
      end
      S_Q_DU:  req.dep_raddr = u;
      S_Q_DV:  req.dep_raddr = v;
      S_L1_A:  req.anc_raddr = {j, u};
      S_L1_B:  req.dep_raddr = fix_rd;
      S_L1_C: begin
        if (j != '0) begin
          req.anc_raddr = {lvl_t'(j - 1'b1), u1_next};
        end
      end
      S_L2_A:  req.anc_raddr = {j, u};
      S_L2_B:  req.anc_raddr = {j, v};
      S_L2_C: begin
        if (j != '0) begin
          req.anc_raddr = {lvl_t'(j - 1'b1), u2_next};
        end
      end
      S_FIN_A: req.anc_raddr = {lvl_t'(0), u};
      S_FIN_B: req.dep_raddr = fix_rd;
      default: ;
    endcase
    if (cfg_write) begin
      req.anc_we    = 1'b1;
      req.anc_waddr = {lvl_t'(0), acting(cfg_data)};
      req.anc_wdata = WORD_W'(acting(cfg_data));
      req.dep_we    = 1'b1;
      req.dep_waddr = acting(cfg_data);
      req.dep_wdata = '0;
    end
  end

  tlca_store u_store (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_PIN;
      root_node    <= ROOT_RESET;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_write) begin
        root_node <= cfg_data;
      end
      unique case (state)
        S_PIN: state <= S_IDLE;
        S_IDLE: begin
          if (start) begin
            unique case (mode)
              MODE_LOAD: begin
                u <= node_a[NODE_W-1:0];
                v <= node_b[NODE_W-1:0];
                if (in_range(node_a) && in_range(node_b) &&
                    (node_a[NODE_W-1:0] != aroot)) begin
                  state <= S_LD_RD;
                end
              end
              MODE_BUILD: state <= S_B_PIN;
              MODE_QUERY: begin
                u     <= fix_node(node_a, aroot);
                v     <= fix_node(node_b, aroot);
                state <= S_Q_DU;
              end
              default: ;
            endcase
          end
        end
        S_LD_RD: state <= S_LD_WR;
        S_LD_WR: state <= S_IDLE;
        S_B_PIN: begin
          j     <= lvl_t'(1);
          i     <= '0;
          state <= S_B_RD1;
        end
        S_B_RD1: state <= S_B_RD2;
        S_B_RD2: state <= S_B_WR;
        S_B_WR: begin
          if (b_last) begin
            result_valid <= 1'b1;
            kind         <= KIND_BUILD;
            ancestor     <= '0;
            path_length  <= '0;
            state        <= S_IDLE;
          end else begin
            i     <= i_next;
            j     <= j_next;
            state <= S_B_RD2;
          end
        end
        S_Q_DU: state <= S_Q_DV;
        S_Q_DV: begin
          du0   <= rsp.dep_rdata;
          state <= S_Q_SW;
        end
        S_Q_SW: begin
          dv0 <= rsp.dep_rdata;
          if (rsp.dep_rdata > du0) begin
            u    <= v;
            v    <= u;
            dcur <= rsp.dep_rdata;
            dvt  <= du0;
          end else begin
            dcur <= du0;
            dvt  <= rsp.dep_rdata;
          end
          j     <= lvl_t'(LEVELS - 1);
          state <= S_L1_A;
        end
        S_L1_A: state <= S_L1_B;
        S_L1_B: begin
          w     <= fix_rd;
          state <= S_L1_C;
        end
        S_L1_C: begin
          if (take1) begin
            u    <= w;
            dcur <= rsp.dep_rdata;
          end
          if (j == '0) begin
            state <= S_CHK;
          end else begin
            j     <= lvl_t'(j - 1'b1);
            state <= S_L1_B;
          end
        end
        S_CHK: begin
          if (u == v) begin
            result_valid <= 1'b1;
            kind         <= KIND_QUERY;
            ancestor     <= WORD_W'(u);
            path_length  <= path_len(du0, dv0, dcur);
            state        <= S_IDLE;
          end else begin
            j     <= lvl_t'(LEVELS - 1);
            state <= S_L2_A;
          end
        end
        S_L2_A: state <= S_L2_B;
        S_L2_B: begin
          w     <= fix_rd;
          state <= S_L2_C;
        end
        S_L2_C: begin
          if (w != fix_rd) begin
            u <= w;
            v <= fix_rd;
          end
          if (j == '0) begin
            state <= S_FIN_A;
          end else begin
            j     <= lvl_t'(j - 1'b1);
            state <= S_L2_B;
          end
        end
        S_FIN_A: state <= S_FIN_B;
        S_FIN_B: begin
          w     <= fix_rd;
          state <= S_FIN_C;
        end
        S_FIN_C: begin
          result_valid <= 1'b1;
          kind         <= KIND_QUERY;
          ancestor     <= WORD_W'(w);
          path_length  <= path_len(du0, dv0, rsp.dep_rdata);
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
module testbench;
  import tlca_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int unsigned LIMIT = 12_000_000;
  localparam int SETTLE = 100;
  localparam int unsigned DEPTH_MAX = 16'hFFFF;
  localparam int LEN_MAX = 131070;

  typedef struct packed {
    logic [1:0] op;
    word_t      a;
    word_t      b;
  } cmd_t;

  typedef struct packed {
    logic  k;
    word_t anc;
    len_t  len;
  } answer_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  logic [1:0] mode = MODE_LOAD;
  word_t node_a = '0;
  word_t node_b = '0;
  logic  cfg_write = 1'b0;
  word_t cfg_data = '0;
  logic  busy;
  logic  result_valid;
  logic  kind;
  word_t ancestor;
  len_t  path_length;

  tree_lca_distance_binary_lifting dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .node_a       (node_a),
    .node_b       (node_b),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .kind         (kind),
    .ancestor     (ancestor),
    .path_length  (path_length)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  cmd_t        pending_words[$];
  answer_t     awaited_answers[$];
  int          n_fed = 0;
  int          n_taken = 0;
  int          errors = 0;
  int          n_loads = 0;
  int          n_builds = 0;
  int          n_queries = 0;
  int          n_checked = 0;
  int unsigned cycles = 0;
  logic        took = 1'b0;
  bit          calm = 1'b0;

  // ancestor engine mirror
  bit [WORD_W-1:0] hop_tbl [LEVELS][NODES];
  bit [WORD_W-1:0] depth_of [NODES];
  int unsigned     root_reg = ROOT_RESET;

  // stimulus-side view of the tree
  bit          in_tree [NODES];
  int unsigned grown[$];
  int unsigned ready[$];
  int unsigned cur_root = ROOT_RESET;
  bit          pp_on = 1'b0;
  int unsigned pp_x = 0;
  int unsigned pp_y = 0;

  function automatic int unsigned head();
    return (root_reg < NODES) ? root_reg : 0;
  endfunction

  function automatic int unsigned clip(input int unsigned x);
    return (x < NODES) ? x : head();
  endfunction

  function automatic void pin_head();
    hop_tbl[0][head()] = WORD_W'(head());
    depth_of[head()] = '0;
  endfunction

  function automatic int unsigned meet(input int unsigned u0, input int unsigned v0);
    int unsigned u, v, t, w, pu, pv;
    int j;
    u = u0;
    v = v0;
    if (depth_of[v] > depth_of[u]) begin
      t = u;
      u = v;
      v = t;
    end
    for (j = LEVELS - 1; j >= 0; j--) begin
      w = clip(hop_tbl[j][u]);
      if (depth_of[w] >= depth_of[v]) u = w;
    end
    if (u == v) return u;
    for (j = LEVELS - 1; j >= 0; j--) begin
      pu = clip(hop_tbl[j][u]);
      pv = clip(hop_tbl[j][v]);
      if (pu != pv) begin
        u = pu;
        v = pv;
      end
    end
    return clip(hop_tbl[0][u]);
  endfunction

  function automatic void absorb(input logic [1:0] op, input int unsigned a,
                                 input int unsigned b);
    int unsigned d, u, v, l;
    int len;
    answer_t e;
    case (op)
      MODE_LOAD: begin
        n_loads++;
        if (a < NODES && b < NODES && a != head()) begin
          d = depth_of[b] + 1;
          if (d > DEPTH_MAX) d = DEPTH_MAX;
          hop_tbl[0][a] = WORD_W'(b);
          depth_of[a] = WORD_W'(d);
        end
      end
      MODE_BUILD: begin
        n_builds++;
        pin_head();
        for (int j = 1; j < LEVELS; j++)
          for (int unsigned i = 0; i < NODES; i++)
            hop_tbl[j][i] = hop_tbl[j-1][clip(hop_tbl[j-1][i])];
        e.k = KIND_BUILD;
        e.anc = '0;
        e.len = '0;
        awaited_answers = {awaited_answers, e};
      end
      MODE_QUERY: begin
        n_queries++;
        u = clip(a);
        v = clip(b);
        l = meet(u, v);
        len = int'(depth_of[u]) + int'(depth_of[v]) - 2 * int'(depth_of[l]);
        if (len < 0) len = 0;
        if (len > LEN_MAX) len = LEN_MAX;
        e.k = KIND_QUERY;
        e.anc = WORD_W'(l);
        e.len = LEN_W'(len);
        awaited_answers = {awaited_answers, e};
      end
      default: begin
      end
    endcase
  endfunction

  // monitor: result check, then command/config accept
  always @(posedge clk) begin
    answer_t e;
    cycles++;
    took <= !rst && start && !busy;
    if (rst) begin
      root_reg = ROOT_RESET;
      pin_head();
    end else begin
      if (result_valid) begin
        if (awaited_answers.size() == 0) begin
          $error("unexpected result word: kind %0d ancestor %0d path_length %0d",
                 kind, ancestor, path_length);
          errors++;
        end else begin
          e = awaited_answers.pop_front();
          n_checked++;
          if (kind !== e.k) begin
            $error("kind: expected %0d, got %0d", e.k, kind);
            errors++;
          end
          if (ancestor !== e.anc) begin
            $error("ancestor: expected %0d, got %0d", e.anc, ancestor);
            errors++;
          end
          if (path_length !== e.len) begin
            $error("path_length: expected %0d, got %0d", e.len, path_length);
            errors++;
          end
        end
      end
      if (cfg_write) begin
        root_reg = cfg_data;
        pin_head();
      end
      if (start && !busy) begin
        n_taken++;
        absorb(mode, node_a, node_b);
      end
    end
    if (cycles >= LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // driver
  always @(negedge clk) begin
    cmd_t c;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 32)) begin
        c = pending_words.pop_front();
        start <= 1'b1;
        mode <= c.op;
        node_a <= c.a;
        node_b <= c.b;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic feed(input logic [1:0] op, input int unsigned a, input int unsigned b);
    cmd_t c;
    c.op = op;
    c.a = WORD_W'(a);
    c.b = WORD_W'(b);
    pending_words = {pending_words, c};
    n_fed++;
  endtask

  task automatic settle(input int extra);
    do @(negedge clk);
    while (n_taken != n_fed || awaited_answers.size() != 0 || busy);
    repeat (extra) @(negedge clk);
  endtask

  task automatic set_root(input int unsigned v);
    settle(SETTLE);
    cfg_write <= 1'b1;
    cfg_data <= WORD_W'(v);
    @(negedge clk);
    cfg_write <= 1'b0;
    cur_root = v;
  endtask

  function automatic int unsigned any_grown();
    return grown[$urandom_range(grown.size() - 1)];
  endfunction

  function automatic int unsigned any_ready();
    return ready[$urandom_range(ready.size() - 1)];
  endfunction

  // ignored words: spare mode, or a load aimed at the root
  task automatic noise();
    if ($urandom_range(1))
      feed(MODE_SPARE, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF));
    else
      feed(MODE_LOAD, cur_root, any_grown());
  endtask

  task automatic add_child();
    int unsigned a, b, back;
    do a = $urandom_range(NODES - 1);
    while (in_tree[a]);
    back = (grown.size() > 8) ? 7 : grown.size() - 1;
    if ($urandom_range(1))
      b = grown[grown.size() - 1 - $urandom_range(back)];
    else
      b = any_grown();
    in_tree[a] = 1'b1;
    grown = {grown, a};
    feed(MODE_LOAD, a, b);
  endtask

  // reparent a node that is already in place
  task automatic move_node(input bit built);
    int unsigned a;
    do a = built ? any_ready() : any_grown();
    while (a == cur_root);
    feed(MODE_LOAD, a, built ? any_ready() : any_grown());
  endtask

  task automatic random_ask();
    int unsigned a, b, r;
    a = any_ready();
    b = any_ready();
    r = $urandom_range(9);
    if (r == 0) b = a;
    else if (r == 1) b = cur_root;
    else if (r == 2) a = $urandom_range(1) ? 0 : 16'hFFFF;
    else if (pp_on && r == 3) a = pp_x;
    else if (pp_on && r == 4) b = pp_y;
    if ($urandom_range(1)) feed(MODE_QUERY, a, b);
    else feed(MODE_QUERY, b, a);
  endtask

  task automatic query_phase(input int count, input int move_pct);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 6) noise();
      else if (r < 6 + move_pct) move_node(1'b1);
      else random_ask();
    end
  endtask

  initial begin
    int r;
    in_tree[ROOT_RESET] = 1'b1;
    grown = {grown, int'(ROOT_RESET)};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    feed(MODE_SPARE, 16'hFFFF, 16'hFFFF);
    feed(MODE_SPARE, 0, 0);
    feed(MODE_LOAD, 16'hFFFF, ROOT_RESET);
    feed(MODE_LOAD, 0, 16'hFFFF);
    in_tree[16'hFFFF] = 1'b1;
    in_tree[0] = 1'b1;
    grown = {grown, 32'hFFFF};
    grown = {grown, 32'h0};
    feed(MODE_LOAD, ROOT_RESET, 0);
    for (int i = 0; i < 300; i++) begin
      r = $urandom_range(39);
      if (r < 2) noise();
      else if (r == 2) move_node(1'b0);
      else add_child();
    end
    feed(MODE_BUILD, $urandom_range(16'hFFFF), $urandom_range(16'hFFFF));
    ready = grown;

    feed(MODE_QUERY, 0, 16'hFFFF);
    feed(MODE_QUERY, 16'hFFFF, 0);
    feed(MODE_QUERY, ROOT_RESET, ROOT_RESET);
    feed(MODE_QUERY, ROOT_RESET, 0);
    r = any_ready();
    feed(MODE_QUERY, r, r);
    query_phase(300, 0);
    settle(0);
    calm = 1'b1;
    query_phase(250, 0);
    calm = 1'b0;
    query_phase(100, 0);

    set_root(16'hFFFF);
    query_phase(200, 8);

    // two nodes taking turns as each other's parent
    set_root(0);
    pp_x = any_ready();
    while (pp_x == 0) pp_x = any_ready();
    pp_y = any_ready();
    while (pp_y == 0 || pp_y == pp_x) pp_y = any_ready();
    for (int k = 0; k < 40; k++) begin
      if (k % 2 == 0) feed(MODE_LOAD, pp_x, pp_y);
      else feed(MODE_LOAD, pp_y, pp_x);
    end
    pp_on = 1'b1;
    feed(MODE_QUERY, pp_x, pp_y);
    feed(MODE_QUERY, pp_y, pp_x);
    feed(MODE_QUERY, pp_x, 0);
    feed(MODE_QUERY, 0, pp_y);
    feed(MODE_QUERY, pp_x, pp_x);
    query_phase(200, 0);

    set_root(any_ready());
    query_phase(200, 5);

    settle(SETTLE);
    $display("Covered %0d loads, %0d table builds, %0d pair queries over four root values;",
             n_loads, n_builds, n_queries);
    $display("%0d result words compared, %0d mismatches.", n_checked, errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tlca_pkg.sv
hw/rtl/tlca_store.sv
hw/rtl/tree_lca_distance_binary_lifting.sv
test/testbench.sv
